/* rtl/bmu_pkg.sv */
// ----------------------------------------------------------------------------
// Breakpoint match unit package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bmu_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int DEF_ID_BITS = 16;
	localparam int ADDR_W = 29;
	localparam int HITS_W = 32;
	localparam int RID_W = 16;
	localparam logic [31:0] ADDR_MASK = 32'h1FFF_FFFF;
	localparam logic [31:0] PC_STEP = 32'd4;

	typedef enum logic [3:0] {
		CMD_CHECK_EXEC = 4'd0,
		CMD_CHECK_MEM = 4'd1,
		CMD_ADD = 4'd2,
		CMD_REMOVE = 4'd3,
		CMD_SET_ENABLE = 4'd4,
		CMD_CLEAR_ALL = 4'd5,
		CMD_PAUSE = 4'd6,
		CMD_RESUME = 4'd7,
		CMD_STEP_IN = 4'd8,
		CMD_STEP_NEXT = 4'd9,
		CMD_RUN_TO = 4'd10,
		CMD_QUERY = 4'd11
	} cmd_t;

	localparam logic [1:0] KIND_EXEC = 2'd0;
	localparam logic [1:0] KIND_ACCESS = 2'd3;

	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_IN = 2'd1;
	localparam logic [1:0] STEP_NEXT = 2'd2;
	localparam logic [1:0] STEP_RUN_TO = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the input beat
		logic execute;  // apply the latched command to the table
	} dp_cmd_t;

endpackage

/* rtl/breakpoint_match_unit.sv */
// ----------------------------------------------------------------------------
// Breakpoint match unit
// Breakpoint table with exec/memory matching and single-step control.
// ----------------------------------------------------------------------------
// Sequencing: the input beat is latched on acceptance, the command executes
// in S_EXEC and writes the result register, and the result beat is then
// offered in S_OUT. The controller handles one command at a time (load,
// execute, hand-off) and takes no new beat until the result beat is taken.
// Reset: arst_n clears the table, step mode and pause; next id becomes 1.
module breakpoint_match_unit import bmu_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES,
	parameter int ID_BITS = DEF_ID_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[3:0], address[35:4], bp_kind[37:36], entry_id[53:38],
	// enable_value[54], zero fill[55]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// break_hit[0], is_paused[1], done_ok[2], result_id[18:3],
	// result_hits[50:19], result_address[79:51], result_kind[81:80],
	// result_enabled[82], zero fill[87:83]
	output logic [87:0] m_tdata
);

	dp_cmd_t     cmd;
	logic [82:0] res;

	bmu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd)
	);

	bmu_datapath #(.ENTRIES(ENTRIES), .ID_BITS(ID_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_command(s_tdata[3:0]), .in_address(s_tdata[35:4]),
		.in_kind(s_tdata[37:36]), .in_id(s_tdata[53:38]),
		.in_enable(s_tdata[54]), .res_data(res)
	);

	assign m_tdata = {5'd0, res};

endmodule

/* rtl/bmu_datapath.sv */
// ----------------------------------------------------------------------------
// Breakpoint match datapath
// Breakpoint table, parallel match, priority select and result register.
// ----------------------------------------------------------------------------
module bmu_datapath import bmu_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES,
	parameter int ID_BITS = DEF_ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [3:0]          in_command,
	input  logic [31:0]         in_address,
	input  logic [1:0]          in_kind,
	input  logic [15:0]         in_id,
	input  logic                in_enable,
	output logic [82:0]         res_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// Latched input beat.
	logic [3:0]          cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [31:0]         raw_q;
	logic [1:0]          kind_q;
	logic [ID_BITS-1:0]  id_q;
	logic                en_q;

	// Table state.
	logic [ENTRIES-1:0]  valid_q;
	logic [ID_BITS-1:0]  sid_q [ENTRIES];
	logic [ADDR_W-1:0]   saddr_q [ENTRIES];
	logic [1:0]          skind_q [ENTRIES];
	logic                sen_q [ENTRIES];
	logic [HITS_W-1:0]   shits_q [ENTRIES];
	logic [ID_BITS-1:0]  next_id_q;
	logic                paused_q;
	logic [1:0]          step_q;
	logic [ADDR_W-1:0]   target_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			raw_q <= in_address;
			addr_q <= in_address[ADDR_W-1:0];
			kind_q <= in_kind;
			id_q <= ID_BITS'({16'd0, in_id} & {32{1'b1}});
			en_q <= in_enable;
		end
	end

	// Per-entry match vectors and the entry count.
	logic [ENTRIES-1:0] exec_m, mem_m, id_m;
	logic [CW-1:0]      used;
	always_comb begin
		used = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			exec_m[i] = valid_q[i] && sen_q[i] && skind_q[i] == KIND_EXEC &&
				saddr_q[i] == addr_q;
			mem_m[i] = valid_q[i] && sen_q[i] && saddr_q[i] == addr_q &&
				(skind_q[i] == kind_q || skind_q[i] == KIND_ACCESS);
			id_m[i] = valid_q[i] && sid_q[i] == id_q;
			used = used + CW'(valid_q[i]);
		end
	end

	logic [ENTRIES-1:0] sel_m;
	logic               sel_any;
	logic [IW-1:0]      sel_i;
	always_comb begin
		unique case (cmd_q)
			CMD_CHECK_EXEC: sel_m = exec_m;
			CMD_CHECK_MEM: sel_m = mem_m;
			default: sel_m = id_m;
		endcase
		sel_any = |sel_m;
		sel_i = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (sel_m[i]) sel_i = IW'(i);
	end

	logic step_brk;
	assign step_brk = step_q == STEP_IN ||
		((step_q == STEP_NEXT || step_q == STEP_RUN_TO) && addr_q == target_q);

	logic [31:0] over_t;
	assign over_t = (raw_q + PC_STEP) & ADDR_MASK;

	// Result fields.
	logic               r_hit, r_ok, r_rep, r_paused;
	logic [15:0]        r_id;
	logic [HITS_W-1:0]  r_hits;
	logic [HITS_W-1:0]  sel_hits;
	assign sel_hits = shits_q[sel_i];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			next_id_q <= ID_BITS'(1);
			paused_q <= 1'b0;
			step_q <= STEP_NONE;
			target_q <= '0;
		end else if (cmd.execute) begin
			unique case (cmd_q)
				CMD_CHECK_EXEC, CMD_CHECK_MEM: begin
					if (cmd_q == CMD_CHECK_EXEC && step_brk) begin
						step_q <= STEP_NONE;
						paused_q <= 1'b1;
					end else if (sel_any) begin
						shits_q[sel_i] <= sel_hits + 1'b1;
						paused_q <= 1'b1;
						step_q <= STEP_NONE;
					end
				end
				CMD_ADD: begin
					if (used < CW'(ENTRIES)) begin
						valid_q[used[IW-1:0]] <= 1'b1;
						sid_q[used[IW-1:0]] <= next_id_q;
						saddr_q[used[IW-1:0]] <= addr_q;
						skind_q[used[IW-1:0]] <= kind_q;
						sen_q[used[IW-1:0]] <= 1'b1;
						shits_q[used[IW-1:0]] <= '0;
						next_id_q <= next_id_q + 1'b1;
					end
				end
				CMD_REMOVE: begin
					if (sel_any) begin
						// Shift later entries down one place.
						for (int i = 0; i < ENTRIES - 1; i++)
							if (IW'(i) >= sel_i) begin
								sid_q[i] <= sid_q[i+1];
								saddr_q[i] <= saddr_q[i+1];
								skind_q[i] <= skind_q[i+1];
								sen_q[i] <= sen_q[i+1];
								shits_q[i] <= shits_q[i+1];
							end
						valid_q[used[IW-1:0] - 1'b1] <= 1'b0;
					end
				end
				CMD_SET_ENABLE: if (sel_any) sen_q[sel_i] <= en_q;
				CMD_CLEAR_ALL: valid_q <= '0;
				CMD_PAUSE: if (!paused_q) begin
					paused_q <= 1'b1;
					step_q <= STEP_NONE;
				end
				CMD_RESUME: if (paused_q) begin
					paused_q <= 1'b0;
					step_q <= STEP_NONE;
				end
				CMD_STEP_IN: begin
					step_q <= STEP_IN;
					paused_q <= 1'b0;
				end
				CMD_STEP_NEXT: begin
					step_q <= STEP_NEXT;
					target_q <= over_t[ADDR_W-1:0];
					paused_q <= 1'b0;
				end
				CMD_RUN_TO: begin
					step_q <= STEP_RUN_TO;
					target_q <= addr_q;
					paused_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Result word, computed from pre-update state.
	always_comb begin
		r_hit = 1'b0;
		r_ok = 1'b0;
		r_rep = 1'b0;
		r_id = '0;
		r_hits = sel_hits;
		r_paused = paused_q;
		unique case (cmd_q)
			CMD_CHECK_EXEC, CMD_CHECK_MEM: begin
				if (cmd_q == CMD_CHECK_EXEC && step_brk) begin
					r_hit = 1'b1;
					r_paused = 1'b1;
				end else if (sel_any) begin
					r_hit = 1'b1;
					r_ok = 1'b1;
					r_rep = 1'b1;
					r_paused = 1'b1;
					r_hits = sel_hits + 1'b1;
				end
			end
			CMD_ADD: if (used < CW'(ENTRIES)) begin
				r_ok = 1'b1;
				r_id = 16'(next_id_q);
			end
			CMD_REMOVE, CMD_SET_ENABLE: r_ok = sel_any;
			CMD_QUERY: begin
				r_ok = sel_any;
				r_rep = sel_any;
			end
			CMD_PAUSE: r_paused = 1'b1;
			CMD_RESUME, CMD_STEP_IN, CMD_STEP_NEXT, CMD_RUN_TO: r_paused = 1'b0;
			default: ;
		endcase
		if (r_rep) r_id = 16'(sid_q[sel_i]);
	end

	logic [82:0] res_q;
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_q <= {r_rep ? sen_q[sel_i] : 1'b0,
				r_rep ? skind_q[sel_i] : 2'b0,
				r_rep ? saddr_q[sel_i] : {ADDR_W{1'b0}},
				r_rep ? r_hits : {HITS_W{1'b0}},
				r_id, r_ok, r_paused, r_hit};
		end
	end
	assign res_data = res_q;

endmodule

/* rtl/bmu_ctrl.sv */
// ----------------------------------------------------------------------------
// Breakpoint match controller
// Sequences load, execute and result hand-off for one beat at a time.
// ----------------------------------------------------------------------------
module bmu_ctrl import bmu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;
	state_t state_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign cmd.load = in_valid && in_ready;
	assign cmd.execute = state_q == S_EXEC;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
